@@ hw/rtl/mwsr_pkg.sv @@
// shared constants, register and mode codes, and types of the moving window reducer
package mwsr_pkg;

  localparam int SMP_W  = 32;   // sample word after sign extension
  localparam int OUT_W  = 48;   // Q32.16 result word
  localparam int ACC_W  = 56;   // wide accumulator, holds any unclipped result
  localparam int FRAC_W = 16;   // fraction bits of Q16.16 and Q32.16

  // reduction modes
  localparam logic [2:0] MODE_SUM    = 3'd0;
  localparam logic [2:0] MODE_MEAN   = 3'd1;
  localparam logic [2:0] MODE_COUNT  = 3'd2;
  localparam logic [2:0] MODE_PROD   = 3'd3;
  localparam logic [2:0] MODE_MIN    = 3'd4;
  localparam logic [2:0] MODE_MAX    = 3'd5;
  localparam logic [2:0] MODE_MEDIAN = 3'd6;
  localparam logic [2:0] MODE_KERNEL = 3'd7;

  // register indexes (word address)
  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_BACK  = 2'd1;
  localparam logic [1:0] REG_AHEAD = 2'd2;

  // input word kinds
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_WEIGHT = 1'b1;

  typedef struct packed {
    logic clear;
    logic insert;
    logic shift;
  } sort_ctrl_t;

endpackage

@@ hw/rtl/mwsr_window_mem.sv @@
// window sample memory: circular buffer with per-entry valid bits
module mwsr_window_mem #(
  parameter int DEPTH       = 31,
  parameter int SAMPLE_BITS = 32,
  localparam int AW         = $clog2(DEPTH)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [AW-1:0]          wr_addr,
  input  logic                   wr_ok,
  input  logic [SAMPLE_BITS-1:0] wr_val,
  input  logic                   rd_en,
  input  logic [AW-1:0]          rd_addr,
  input  logic                   clr,
  output logic                   rd_ok,
  output logic [SAMPLE_BITS-1:0] rd_val
);

  logic [SAMPLE_BITS:0] mem [DEPTH];
  logic [DEPTH-1:0]     valid;
  logic [SAMPLE_BITS:0] rd_word;
  logic                 rd_live;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_ok, wr_val};
    end
    if (rd_en) begin
      rd_word <= mem[rd_addr];
    end
  end

  // entries not written since the last clear read as missing
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      rd_live <= 1'b0;
    end else begin
      if (clr) begin
        valid <= '0;
      end else if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_live <= valid[rd_addr];
      end
    end
  end

  assign rd_ok  = rd_live & rd_word[SAMPLE_BITS];
  assign rd_val = rd_word[SAMPLE_BITS-1:0];

endmodule

@@ hw/rtl/mwsr_weight_mem.sv @@
// kernel weight memory, one write and one registered read port
module mwsr_weight_mem #(
  parameter int DEPTH = 31,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [AW-1:0]                wr_addr,
  input  logic [mwsr_pkg::SMP_W-1:0]   wr_data,
  input  logic                         rd_en,
  input  logic [AW-1:0]                rd_addr,
  output logic [mwsr_pkg::SMP_W-1:0]   rd_data
);

  logic [mwsr_pkg::SMP_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/mwsr_sort.sv @@
// insertion sorter for the median, drained by shifting toward slot 0
module mwsr_sort #(
  parameter int DEPTH = 31,
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  mwsr_pkg::sort_ctrl_t               ctrl,
  input  logic signed [mwsr_pkg::SMP_W-1:0]  din,
  output logic signed [mwsr_pkg::SMP_W-1:0]  low0,
  output logic signed [mwsr_pkg::SMP_W-1:0]  low1
);

  logic signed [mwsr_pkg::SMP_W-1:0] srt [DEPTH];
  logic signed [mwsr_pkg::SMP_W-1:0] ins [DEPTH];
  logic [DEPTH-1:0]                  le;
  logic [CW-1:0]                     cnt;

  // le marks the filled prefix that stays in place
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      le[i] = (CW'(i) < cnt) && (srt[i] <= din);
    end
    ins[0] = le[0] ? srt[0] : din;
    for (int i = 1; i < DEPTH; i++) begin
      if (le[i]) begin
        ins[i] = srt[i];
      end else if (le[i-1]) begin
        ins[i] = din;
      end else begin
        ins[i] = srt[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctrl.clear) begin
      cnt <= '0;
    end else if (ctrl.insert) begin
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.insert) begin
      for (int i = 0; i < DEPTH; i++) begin
        srt[i] <= ins[i];
      end
    end else if (ctrl.shift) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        srt[i] <= srt[i+1];
      end
    end
  end

  assign low0 = srt[0];
  assign low1 = srt[1];

endmodule

@@ hw/rtl/mwsr_div.sv @@
// restoring divider, one quotient bit per cycle
module mwsr_div #(
  parameter int NW  = 37,
  parameter int DW  = 5,
  localparam int SW = $clog2(NW + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient
);

  logic [DW-1:0] rem;
  logic [DW-1:0] dvs;
  logic [SW-1:0] steps;
  logic          busy;
  logic [DW:0]   shl;
  logic [DW:0]   trial;
  logic          fits;

  assign shl   = {rem, quotient[NW-1]};
  assign fits  = shl >= {1'b0, dvs};
  assign trial = shl - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= SW'(NW);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == SW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? trial[DW-1:0] : shl[DW-1:0];
      quotient <= {quotient[NW-2:0], fits};
    end
  end

endmodule

@@ hw/rtl/moving_window_series_reducer.sv @@
// top level of the moving window series reducer
//
// input channel: one word per handshake (in_valid high, in_stall low). a word
// is either a series sample (value, present flag, series_end) or a kernel
// weight load into weight_slot. output channel: one result word per window
// position, held in an output register until out_stall drops.
// configuration: apb-style port, reduce_mode at 0x0, look_back at 0x4,
// look_ahead at 0x8; write only while the block is idle.
// sequence: a weight load or a sample that completes no window leaves the
// block idle. each result walks its lb+la+1 taps through the window memory,
// with a memory read, a multiply and an accumulate step per tap, then a
// finish step and a hand-off; mean adds a pass through the bit-serial
// divider and median a drain of the sorter. a series_end sample flushes up
// to look_ahead+1 results back to back through the same tap loop.
// in_stall is high from the accepted sample until its last result is in the
// output register; a full output register stalls the walk, so a slow receiver
// holds everything. reset clears the window to missing, the pending count
// and the registers; kernel weights are undefined until loaded.
module moving_window_series_reducer #(
  parameter int MAX_SIDE    = 15,
  parameter int SAMPLE_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // input words
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               action,
  input  logic signed [31:0] sample_value,
  input  logic               present,
  input  logic               series_end,
  input  logic [4:0]         weight_slot,
  // result words
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [47:0] reduced,
  output logic               reduced_present,
  output logic               saturated,
  output logic               run_end
);

  localparam int DEPTH = 2 * MAX_SIDE + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int TW    = $clog2(DEPTH + 1);
  localparam int IW    = TW + 2;
  localparam int SMP_W = mwsr_pkg::SMP_W;
  localparam int OUT_W = mwsr_pkg::OUT_W;
  localparam int ACC_W = mwsr_pkg::ACC_W;
  localparam int SUM_W = SMP_W + TW;

  localparam logic [63:0] LIM_POS = (64'd1 << (OUT_W - 1)) - 64'd1;
  localparam logic [63:0] LIM_NEG = 64'd1 << (OUT_W - 1);
  localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W - 1){1'b1}}};
  localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W - 1){1'b0}}};
  localparam logic signed [OUT_W-1:0] ONE_Q = OUT_W'(1) << mwsr_pkg::FRAC_W;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_ACC  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_MED  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  function automatic logic [3:0] side_sat(input logic [3:0] v);
    side_sat = (32'(v) > MAX_SIDE) ? 4'(MAX_SIDE) : v;
  endfunction

  // control state
  logic [2:0]    state;
  logic [2:0]    mode;
  logic [3:0]    lb;
  logic [3:0]    la;
  logic [AW-1:0] head;
  logic [3:0]    lead;
  logic [3:0]    center;
  logic          end_flag;
  logic [TW-1:0] j;
  logic [TW-1:0] dcnt;

  // tap and accumulator registers
  logic                    tap_neg;
  logic                    tap_p;
  logic signed [SMP_W-1:0] tap_v;
  logic [63:0]             ph_hi;
  logic [47:0]             ph_lo;
  logic signed [63:0]      kprod;
  logic [TW-1:0]           n;
  logic signed [SUM_W-1:0] sum;
  logic signed [ACC_W-1:0] kacc;
  logic signed [OUT_W-1:0] r_prod;
  logic                    psat;
  logic                    any_miss;
  logic signed [SMP_W-1:0] mm;
  logic signed [ACC_W-1:0] res;
  logic                    res_ok;
  logic                    res_sat;

  // combinational
  logic                    cfg_wr;
  logic                    take;
  logic                    is_sample;
  logic [AW-1:0]           head_new;
  logic [TW-1:0]           taps;
  logic signed [IW-1:0]    idx;
  logic signed [IW-1:0]    diff;
  logic signed [IW-1:0]    wrap;
  logic [AW-1:0]           rd_addr;
  logic                    rd_en;
  logic                    wm_rd_ok;
  logic [SAMPLE_BITS-1:0]  wm_rd_val;
  logic [SMP_W-1:0]        wt_rd;
  logic                    wt_wr;
  logic signed [SMP_W-1:0] v_ext;
  logic [OUT_W-1:0]        rp_mag;
  logic [SMP_W-1:0]        v_mag;
  logic [48:0]             lo_r;
  logic [63:0]             q_raw;
  logic                    neg_p;
  logic [63:0]             lim;
  logic                    p_over;
  logic [63:0]             q_lim;
  logic [63:0]             q_neg;
  logic [63:0]             km;
  logic [63:0]             km_r;
  logic                    mm_take;
  logic [SUM_W-1:0]        s_mag;
  logic [SUM_W-1:0]        div_in;
  logic                    div_start;
  logic                    div_done;
  logic [SUM_W-1:0]        q_div;
  logic signed [SMP_W-1:0] low0;
  logic signed [SMP_W-1:0] low1;
  logic signed [SMP_W:0]   msum;
  logic [TW-1:0]           med_at;
  logic                    n_even;
  logic [ACC_W-OUT_W:0]    res_hi;
  logic                    fits;
  logic [OUT_W-1:0]        clipped;
  logic                    out_free;
  logic                    start_res;
  logic                    win_clr;
  logic signed [ACC_W-1:0] fin_res;
  logic                    fin_ok;
  mwsr_pkg::sort_ctrl_t    sctl;

  assign pready    = 1'b1;
  assign cfg_wr    = psel & penable & pwrite;
  assign in_stall  = (state != S_IDLE);
  assign take      = in_valid & (state == S_IDLE);
  assign is_sample = take & (action == mwsr_pkg::ACT_SAMPLE);
  assign wt_wr     = take & (action == mwsr_pkg::ACT_WEIGHT) & (32'(weight_slot) < DEPTH);
  assign head_new  = (32'(head) == DEPTH - 1) ? '0 : head + 1'b1;
  assign taps      = TW'(lb) + TW'(la) + TW'(1);
  assign out_free  = ~out_valid | ~out_stall;

  // register readback
  always_comb begin
    unique case (paddr[3:2])
      mwsr_pkg::REG_MODE:  prdata = {29'd0, mode};
      mwsr_pkg::REG_BACK:  prdata = {28'd0, lb};
      mwsr_pkg::REG_AHEAD: prdata = {28'd0, la};
      default:             prdata = '0;
    endcase
  end

  // tap j of the window centered at 'center' sits lb+center-j samples back
  // from the newest; a negative distance lies beyond the newest sample
  assign idx     = $signed(IW'(center) + IW'(lb) - IW'(j));
  assign diff    = $signed(IW'(head)) - idx;
  assign wrap    = diff[IW-1] ? diff + $signed(IW'(DEPTH)) : diff;
  assign rd_addr = wrap[AW-1:0];
  assign rd_en   = (state == S_RD);

  mwsr_window_mem #(
    .DEPTH       (DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_win (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (is_sample),
    .wr_addr (head_new),
    .wr_ok   (present),
    .wr_val  (sample_value[SAMPLE_BITS-1:0]),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .clr     (win_clr),
    .rd_ok   (wm_rd_ok),
    .rd_val  (wm_rd_val)
  );

  mwsr_weight_mem #(
    .DEPTH (DEPTH)
  ) u_wt (
    .clk     (clk),
    .wr_en   (wt_wr),
    .wr_addr (AW'(weight_slot)),
    .wr_data (sample_value),
    .rd_en   (rd_en),
    .rd_addr (AW'(j)),
    .rd_data (wt_rd)
  );

  // multiply stage operands
  assign v_ext  = SMP_W'($signed(wm_rd_val));
  assign rp_mag = r_prod[OUT_W-1] ? (~r_prod + 1'b1) : r_prod;
  assign v_mag  = v_ext[SMP_W-1] ? (~v_ext + 1'b1) : v_ext;

  // product step: hi and lo partial products, rounded on the magnitude
  assign lo_r   = {1'b0, ph_lo} + 49'd32768;
  assign q_raw  = ph_hi + 64'(lo_r[48:16]);
  assign neg_p  = r_prod[OUT_W-1] ^ tap_v[SMP_W-1];
  assign lim    = neg_p ? LIM_NEG : LIM_POS;
  assign p_over = q_raw > lim;
  assign q_lim  = p_over ? lim : q_raw;
  assign q_neg  = ~q_lim + 64'd1;

  // kernel tap rounded on the magnitude
  assign km   = kprod[63] ? (~kprod + 64'd1) : kprod;
  assign km_r = (km + 64'd32768) >> mwsr_pkg::FRAC_W;

  assign mm_take = (n == '0) ||
                   ((mode == mwsr_pkg::MODE_MIN) ? (tap_v < mm) : (tap_v > mm));

  // mean: magnitude plus half the count, then divide
  assign s_mag  = sum[SUM_W-1] ? (~sum + 1'b1) : sum;
  assign div_in = s_mag + SUM_W'(n >> 1);
  assign div_start = (state == S_FIN) && (mode == mwsr_pkg::MODE_MEAN) && (n != '0);

  mwsr_div #(
    .NW (SUM_W),
    .DW (TW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_in),
    .divisor  (n),
    .done     (div_done),
    .quotient (q_div)
  );

  // median: drain the sorted taps down to the middle one or two
  assign n_even = ~n[0];
  assign med_at = n_even ? (n >> 1) - 1'b1 : (n >> 1);
  assign msum   = {low0[SMP_W-1], low0} + {low1[SMP_W-1], low1};

  assign sctl.clear  = start_res;
  assign sctl.insert = (state == S_ACC) & tap_p;
  assign sctl.shift  = (state == S_MED) & (dcnt != med_at);

  mwsr_sort #(
    .DEPTH (DEPTH)
  ) u_sort (
    .clk  (clk),
    .rst  (rst),
    .ctrl (sctl),
    .din  (tap_v),
    .low0 (low0),
    .low1 (low1)
  );

  // clip to the 48-bit result range
  assign res_hi  = res[ACC_W-1:OUT_W-1];
  assign fits    = (&res_hi) | ~(|res_hi);
  assign clipped = fits ? res[OUT_W-1:0] : (res[ACC_W-1] ? OUT_MIN : OUT_MAX);

  // result picked at the end of the tap walk; mean and median finish later
  always_comb begin
    fin_ok  = 1'b1;
    fin_res = '0;
    case (mode) inside
      mwsr_pkg::MODE_SUM:    fin_res = ACC_W'(sum);
      mwsr_pkg::MODE_MEAN:   fin_ok  = (n != '0);
      mwsr_pkg::MODE_COUNT:  fin_res = ACC_W'(n) << mwsr_pkg::FRAC_W;
      mwsr_pkg::MODE_PROD:   fin_res = ACC_W'(r_prod);
      mwsr_pkg::MODE_MIN,
      mwsr_pkg::MODE_MAX: begin
        fin_ok  = (n != '0);
        fin_res = ACC_W'(mm);
      end
      mwsr_pkg::MODE_MEDIAN: fin_ok = (n != '0);
      default: begin
        fin_ok  = ~any_miss;
        fin_res = kacc;
      end
    endcase
  end

  // a new result starts on a sample that completes a window or ends the
  // series, or on the next flushed position at series end
  always_comb begin
    start_res = 1'b0;
    win_clr   = 1'b0;
    if (is_sample) begin
      start_res = (lead >= la) | series_end;
    end
    if ((state == S_OUT) && out_free) begin
      start_res = end_flag & (center != '0);
      win_clr   = end_flag & (center == '0);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mode      <= mwsr_pkg::MODE_SUM;
      lb        <= '0;
      la        <= '0;
      head      <= '0;
      lead      <= '0;
      center    <= '0;
      end_flag  <= 1'b0;
      j         <= '0;
      dcnt      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[3:2])
          mwsr_pkg::REG_MODE:  mode <= pwdata[2:0];
          mwsr_pkg::REG_BACK:  lb   <= side_sat(pwdata[3:0]);
          mwsr_pkg::REG_AHEAD: la   <= side_sat(pwdata[3:0]);
          default: ;
        endcase
      end

      // output register loads a word or empties when taken
      if ((state == S_OUT) && out_free) begin
        out_valid <= 1'b1;
      end else if (~out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (is_sample) begin
            head     <= head_new;
            end_flag <= series_end;
            if (lead < la) begin
              lead   <= series_end ? '0 : lead + 1'b1;
              center <= lead;
            end else begin
              lead   <= series_end ? '0 : la;
              center <= la;
            end
            if (start_res) begin
              j     <= '0;
              state <= S_RD;
            end
          end
        end
        S_RD: begin
          state <= S_MUL;
        end
        S_MUL: begin
          state <= S_ACC;
        end
        S_ACC: begin
          j <= j + 1'b1;
          if ((j + 1'b1) == taps) begin
            state <= S_FIN;
          end else begin
            state <= S_RD;
          end
        end
        S_FIN: begin
          dcnt <= '0;
          if (mode == mwsr_pkg::MODE_MEAN && n != '0) begin
            state <= S_DIV;
          end else if (mode == mwsr_pkg::MODE_MEDIAN && n != '0) begin
            state <= S_MED;
          end else begin
            state <= S_OUT;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_OUT;
          end
        end
        S_MED: begin
          if (dcnt == med_at) begin
            state <= S_OUT;
          end else begin
            dcnt <= dcnt + 1'b1;
          end
        end
        S_OUT: begin
          if (out_free) begin
            if (start_res) begin
              center <= center - 1'b1;
              j      <= '0;
              state  <= S_RD;
            end else begin
              state  <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (start_res) begin
      n        <= '0;
      sum      <= '0;
      kacc     <= '0;
      r_prod   <= ONE_Q;
      psat     <= 1'b0;
      any_miss <= 1'b0;
    end

    if (state == S_RD) begin
      tap_neg <= idx[IW-1];
    end

    if (state == S_MUL) begin
      tap_p <= wm_rd_ok & ~tap_neg;
      tap_v <= v_ext;
      ph_hi <= rp_mag[OUT_W-1:16] * v_mag;
      ph_lo <= rp_mag[15:0] * v_mag;
      kprod <= v_ext * $signed(wt_rd);
    end

    if (state == S_ACC) begin
      if (tap_p) begin
        n      <= n + 1'b1;
        sum    <= sum + SUM_W'(tap_v);
        kacc   <= kprod[63] ? kacc - ACC_W'(km_r[47:0]) : kacc + ACC_W'(km_r[47:0]);
        r_prod <= neg_p ? q_neg[OUT_W-1:0] : q_lim[OUT_W-1:0];
        psat   <= psat | p_over;
        if (mm_take) begin
          mm <= tap_v;
        end
      end else begin
        any_miss <= 1'b1;
      end
    end

    if (state == S_FIN) begin
      res     <= fin_res;
      res_ok  <= fin_ok;
      res_sat <= (mode == mwsr_pkg::MODE_PROD) & psat;
    end

    if (state == S_DIV && div_done) begin
      res <= sum[SUM_W-1] ? ACC_W'(0) - ACC_W'(q_div) : ACC_W'(q_div);
    end

    if (state == S_MED && dcnt == med_at) begin
      res <= n_even ? ACC_W'($signed(msum[SMP_W:1])) : ACC_W'(low0);
    end

    if (state == S_OUT && out_free) begin
      reduced         <= res_ok ? $signed(clipped) : '0;
      reduced_present <= res_ok;
      saturated       <= res_ok & (res_sat | ~fits);
      run_end         <= end_flag & (center == '0);
    end
  end

endmodule

@@ hw/rtl/mwsr_checker.sv @@
// port-level checks on the result channel of the moving window reducer
module mwsr_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [47:0] reduced,
  input logic               reduced_present,
  input logic               saturated
);

  // a stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(reduced) &&
      $stable(reduced_present) && $stable(saturated))
    else $error("stalled result word changed");

  // a missing result carries zero and no clip flag
  a_missing: assert property (@(posedge clk) disable iff (rst)
    out_valid && !reduced_present |-> reduced == 48'sd0 && !saturated)
    else $error("missing result not cleared");

  // a clip flag only comes with a present result
  a_clip: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> reduced_present)
    else $error("clip flag on a missing result");

  // reset empties the output register
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word after reset");

endmodule

bind moving_window_series_reducer mwsr_checker u_mwsr_checker (.*);
